// File: hw/rtl/fdre_pkg.sv
`timescale 1ns / 1ps
package fdre_pkg;

   localparam int MAX_SUBCARRIERS_DEF = 256;
   localparam int SAMPLE_BITS_DEF     = 16;

   localparam int              CSR_BITS  = 9;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 9'd64;

   localparam int SUM_BITS    = 42;
   localparam int FRAC_SHIFT  = 16;
   localparam int SCALED_BITS = SUM_BITS + FRAC_SHIFT;
   localparam int ENERGY_BITS = 25;

   localparam int DIV_STEPS  = SCALED_BITS;
   localparam int SQRT_TOP   = ((SCALED_BITS - 1) / 2) * 2;
   localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;
      logic mult;
      logic accum;
      logic div_init;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic out_load;
   } fdre_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic have_prev;
   } fdre_stat_type;

endpackage

// File: hw/rtl/fdre_req_if.sv
`timescale 1ns / 1ps
interface fdre_req_if import fdre_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] real_part;
   logic signed [SAMPLE_BITS-1:0] imag_part;
   logic                          new_capture;

   modport source (output valid, output real_part, output imag_part, output new_capture,
                   input ready);
   modport sink   (input valid, input real_part, input imag_part, input new_capture,
                   output ready);
endinterface

// File: hw/rtl/fdre_rsp_if.sv
`timescale 1ns / 1ps
interface fdre_rsp_if import fdre_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ENERGY_BITS-1:0] energy;

   modport source (output valid, output energy, input ready);
   modport sink   (input valid, input energy, output ready);
endinterface

// File: hw/rtl/fdre_ctrl.sv
`timescale 1ns / 1ps
module fdre_ctrl import fdre_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   input  fdre_stat_type stat,
   output fdre_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 rsp_valid_ff;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:      cmd.load      = req_valid;
         ST_MULT:      cmd.mult      = 1'b1;
         ST_ACCUM:     cmd.accum     = 1'b1;
         ST_DIV_INIT:  cmd.div_init  = 1'b1;
         ST_DIV:       cmd.div_step  = 1'b1;
         ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
         ST_SQRT:      cmd.sqrt_step = 1'b1;
         ST_OUT:       cmd.out_load  = out_free;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (stat.frame_end && stat.have_prev) begin
                  state_ff <= ST_DIV_INIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
                  state_ff <= ST_SQRT_INIT;
               end
               step_ff <= step_ff + 1'b1;
            end
            ST_SQRT_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (step_ff == STEP_BITS'(SQRT_STEPS - 1)) begin
                  state_ff <= ST_OUT;
               end
               step_ff <= step_ff + 1'b1;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/fdre_datapath.sv
`timescale 1ns / 1ps
module fdre_datapath import fdre_pkg::*; #(
   parameter int MAX_SUBCARRIERS = MAX_SUBCARRIERS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_BITS-1:0]           csr_wr_data,
   input  logic signed [SAMPLE_BITS-1:0] req_real_part,
   input  logic signed [SAMPLE_BITS-1:0] req_imag_part,
   input  logic                          req_new_capture,
   input  fdre_cmd_type                  cmd,
   output fdre_stat_type                 stat,
   output logic [ENERGY_BITS-1:0]        rsp_energy
);

   localparam int AW       = (MAX_SUBCARRIERS > 1) ? $clog2(MAX_SUBCARRIERS) : 1;
   localparam int CNT_BITS = ($clog2(MAX_SUBCARRIERS + 1) > CSR_BITS) ?
                             $clog2(MAX_SUBCARRIERS + 1) : CSR_BITS;
   localparam int DW       = SAMPLE_BITS + 1;
   localparam int PW       = 2 * DW;
   localparam int SQ_BITS  = PW + 1;
   localparam int ACC      = (SQ_BITS > SUM_BITS) ? SQ_BITS : SUM_BITS;
   localparam int QB       = SCALED_BITS;

   // sample store and control state
   logic [2*SAMPLE_BITS-1:0]        store_ff [MAX_SUBCARRIERS];
   logic [CSR_BITS-1:0]             csr_ff;
   logic [AW-1:0]                   pos_ff;
   logic                            have_prev_ff;
   logic [SUM_BITS-1:0]             sum_ff;

   // per-request datapath
   logic signed [SAMPLE_BITS-1:0]   re_ff;
   logic signed [SAMPLE_BITS-1:0]   im_ff;
   logic [2*SAMPLE_BITS-1:0]        prev_ff;
   logic [PW-1:0]                   sq_r_ff;
   logic [PW-1:0]                   sq_i_ff;

   // divide and square root
   logic [QB-1:0]                   quo_ff;
   logic [CNT_BITS-1:0]             rem_ff;
   logic [QB-1:0]                   x_ff;
   logic [QB-1:0]                   res_ff;
   logic [QB-1:0]                   bit_ff;
   logic [ENERGY_BITS-1:0]          energy_ff;

   logic [AW-1:0]                   rd_addr;
   logic [CNT_BITS-1:0]             count_eff;
   logic [CNT_BITS-1:0]             pos_next;
   logic signed [DW-1:0]            prev_re;
   logic signed [DW-1:0]            prev_im;
   logic signed [DW-1:0]            dr;
   logic signed [DW-1:0]            di;
   logic signed [PW-1:0]            prod_r;
   logic signed [PW-1:0]            prod_i;
   logic [ACC-1:0]                  acc_sum;
   logic [CNT_BITS:0]               div_sh;
   logic [CNT_BITS:0]               div_sub;
   logic                            div_take;
   logic [QB:0]                     sqrt_t;
   logic                            sqrt_take;

   assign rd_addr = req_new_capture ? '0 : pos_ff;

   always_comb begin
      if (csr_ff == '0) begin
         count_eff = CNT_BITS'(1);
      end else if (CNT_BITS'(csr_ff) > CNT_BITS'(MAX_SUBCARRIERS)) begin
         count_eff = CNT_BITS'(MAX_SUBCARRIERS);
      end else begin
         count_eff = CNT_BITS'(csr_ff);
      end
   end

   assign pos_next       = CNT_BITS'(pos_ff) + CNT_BITS'(1);
   assign stat.frame_end = (pos_next >= count_eff);
   assign stat.have_prev = have_prev_ff;

   assign prev_re = DW'($signed(prev_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]));
   assign prev_im = DW'($signed(prev_ff[SAMPLE_BITS-1:0]));
   assign dr      = DW'(re_ff) - prev_re;
   assign di      = DW'(im_ff) - prev_im;
   assign prod_r  = PW'(dr) * PW'(dr);
   assign prod_i  = PW'(di) * PW'(di);
   assign acc_sum = ACC'(sum_ff) + ACC'(sq_r_ff) + ACC'(sq_i_ff);

   assign div_sh   = {rem_ff, quo_ff[QB-1]};
   assign div_take = (div_sh >= {1'b0, count_eff});
   assign div_sub  = div_sh - {1'b0, count_eff};

   assign sqrt_t    = {1'b0, res_ff} + {1'b0, bit_ff};
   assign sqrt_take = ({1'b0, x_ff} >= sqrt_t);

   assign rsp_energy = energy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         pos_ff       <= '0;
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.load && req_new_capture) begin
            pos_ff       <= '0;
            have_prev_ff <= 1'b0;
            sum_ff       <= '0;
         end
         if (cmd.accum) begin
            if (have_prev_ff) begin
               sum_ff <= acc_sum[SUM_BITS-1:0];
            end
            if (stat.frame_end) begin
               pos_ff <= '0;
               if (!have_prev_ff) begin
                  have_prev_ff <= 1'b1;
                  sum_ff       <= '0;
               end
            end else begin
               pos_ff <= pos_next[AW-1:0];
            end
         end
         if (cmd.div_init) begin
            sum_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prev_ff <= store_ff[rd_addr];
      end
      if (cmd.mult) begin
         store_ff[pos_ff] <= {re_ff, im_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         re_ff <= req_real_part;
         im_ff <= req_imag_part;
      end
      if (cmd.mult) begin
         sq_r_ff <= prod_r;
         sq_i_ff <= prod_i;
      end
      if (cmd.div_init) begin
         quo_ff <= {sum_ff, FRAC_SHIFT'(0)};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[QB-2:0], div_take};
         rem_ff <= div_take ? div_sub[CNT_BITS-1:0] : div_sh[CNT_BITS-1:0];
      end
      if (cmd.sqrt_init) begin
         x_ff   <= quo_ff;
         res_ff <= '0;
         bit_ff <= QB'(1) << SQRT_TOP;
      end else if (cmd.sqrt_step) begin
         if (sqrt_take) begin
            x_ff   <= x_ff - sqrt_t[QB-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.out_load) begin
         energy_ff <= res_ff[ENERGY_BITS-1:0];
      end
   end

endmodule

// File: hw/rtl/frame_difference_rms_energy_top.sv
`timescale 1ns / 1ps
// Frame difference RMS energy. Complex samples arrive one subcarrier per request; each is
// compared with the same subcarrier of the previous frame, kept in an on-chip store, and the
// squared differences are summed. At the end of every frame after the first of a capture
// the block returns floor(256 * sqrt(sum / frame length)), 8 fraction bits. A request
// with new_capture set starts over: that frame only fills the store. Frame length is
// csr_wr_data (0 acts as 1, values above MAX_SUBCARRIERS act as MAX_SUBCARRIERS); write it
// only while idle. A request runs store read, squaring and accumulate in turn. A request
// that ends a frame with a result then goes on through the one-bit-per-cycle divider, which
// runs 58 steps, and the 29-step square root. The finished result sits in an output
// register, so the next request is taken while it waits; a second result waits for it.
module frame_difference_rms_energy_top import fdre_pkg::*; #(
   parameter int MAX_SUBCARRIERS = MAX_SUBCARRIERS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CSR_BITS-1:0] csr_wr_data,
   fdre_req_if.sink            req_chan,
   fdre_rsp_if.source          rsp_chan
);

   fdre_cmd_type  cmd;
   fdre_stat_type stat;
   logic          req_ready;
   logic          rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   fdre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fdre_datapath #(
      .MAX_SUBCARRIERS (MAX_SUBCARRIERS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_real_part   (req_chan.real_part),
      .req_imag_part   (req_chan.imag_part),
      .req_new_capture (req_chan.new_capture),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_energy      (rsp_chan.energy)
   );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import fdre_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 600;
   localparam int REPORT_LINES  = 20;

   localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = ~SAMPLE_MIN;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [SAMPLE_BITS_DEF-1:0] re;
      logic signed [SAMPLE_BITS_DEF-1:0] im;
      logic                              new_capture;
   } sample_type;

   typedef struct {
      bit                     set_len;
      logic [CSR_BITS-1:0]    len;
      sample_type             smp;
      bit                     typed;
      logic [ENERGY_BITS-1:0] energy;
   } step_row_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;

   fdre_req_if req_if ();
   fdre_rsp_if rsp_if ();

   frame_difference_rms_energy_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   // shadow of the frame store, the running sum and the frame length
   logic signed [SAMPLE_BITS_DEF-1:0] store_re    [MAX_SUBCARRIERS_DEF] = '{default: '0};
   logic signed [SAMPLE_BITS_DEF-1:0] store_im    [MAX_SUBCARRIERS_DEF] = '{default: '0};
   bit                                store_valid [MAX_SUBCARRIERS_DEF];
   logic [SUM_BITS-1:0]               diff_sum       = '0;
   int unsigned                       slot_pos       = 0;
   bit                                have_ref_frame = 1'b0;
   logic [CSR_BITS-1:0]               frame_len_reg  = CSR_RESET;

   logic [ENERGY_BITS-1:0] pending_energy [$];
   step_row_type           directed_rows  [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_trigger       = 1'b0;
   int error_count        = 0;
   int sent_count         = 0;
   int checked_count      = 0;
   int cycle_count        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned frame_len();
      if (frame_len_reg == '0) return 1;
      if (frame_len_reg > MAX_SUBCARRIERS_DEF) return MAX_SUBCARRIERS_DEF;
      return frame_len_reg;
   endfunction

   function automatic int unsigned store_slot();
      return (slot_pos >= MAX_SUBCARRIERS_DEF) ? MAX_SUBCARRIERS_DEF - 1 : slot_pos;
   endfunction

   function automatic logic [31:0] root_floor(input logic [63:0] x);
      logic [31:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = {32'd0, r | (32'd1 << b)};
         if (t * t <= x) r = r | (32'd1 << b);
      end
      return r;
   endfunction

   task automatic predict_energy(input sample_type s, input bit typed,
                                 input logic [ENERGY_BITS-1:0] typed_energy);
      int unsigned n;
      int unsigned slot;
      longint      dr;
      longint      di;
      logic [63:0] scaled;
      n = frame_len();
      if (s.new_capture) begin
         diff_sum       = '0;
         slot_pos       = 0;
         have_ref_frame = 1'b0;
      end
      slot = store_slot();
      if (have_ref_frame) begin
         dr       = longint'(s.re) - longint'(store_re[slot]);
         di       = longint'(s.im) - longint'(store_im[slot]);
         diff_sum = diff_sum + SUM_BITS'(dr * dr + di * di);
      end
      store_re[slot]    = s.re;
      store_im[slot]    = s.im;
      store_valid[slot] = 1'b1;
      if (slot + 1 < n) begin
         slot_pos = slot + 1;
         return;
      end
      slot_pos = 0;
      if (!have_ref_frame) begin
         have_ref_frame = 1'b1;
         diff_sum       = '0;
         return;
      end
      scaled = (64'(diff_sum) << FRAC_SHIFT) / 64'(n);
      pending_energy.push_back(typed ? typed_energy : ENERGY_BITS'(root_floor(scaled)));
      diff_sum = '0;
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_LINES) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic push_sample(input sample_type s, input bit typed,
                              input logic [ENERGY_BITS-1:0] typed_energy);
      sample_type t;
      t = s;
      // never let a frame compare against a store entry that was not written
      if (!t.new_capture && have_ref_frame && !store_valid[store_slot()]) t.new_capture = 1'b1;
      req_if.valid       <= 1'b1;
      req_if.real_part   <= t.re;
      req_if.imag_part   <= t.im;
      req_if.new_capture <= t.new_capture;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
      predict_energy(t, typed, typed_energy);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_len(input logic [CSR_BITS-1:0] len);
      settle();
      csr_wr_data <= len;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      frame_len_reg  = len;
   endtask

   task automatic add_len(input int unsigned len);
      step_row_type row;
      row         = '{default: '0};
      row.set_len = 1'b1;
      row.len     = CSR_BITS'(len);
      directed_rows.push_back(row);
   endtask

   task automatic add_sample(input int re, input int im, input bit nc, input bit typed,
                             input int unsigned energy);
      step_row_type row;
      row                 = '{default: '0};
      row.smp.re          = SAMPLE_BITS_DEF'(re);
      row.smp.im          = SAMPLE_BITS_DEF'(im);
      row.smp.new_capture = nc;
      row.typed           = typed;
      row.energy          = ENERGY_BITS'(energy);
      directed_rows.push_back(row);
   endtask

   function automatic logic signed [SAMPLE_BITS_DEF-1:0] random_value(
      input logic signed [SAMPLE_BITS_DEF-1:0] near);
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2, 3, 4: return near + SAMPLE_BITS_DEF'($urandom_range(0, 64)) - SAMPLE_BITS_DEF'(32);
         default: return SAMPLE_BITS_DEF'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic [CSR_BITS-1:0] len, input int items,
                            input idle_mode_type mode, input bit hold, input int restart_odds);
      sample_type s;
      write_frame_len(len);
      sender_idle_pct    = (mode == IDLE_SENDER) ? 45 : (mode == IDLE_BOTH) ? 36 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 45 : (mode == IDLE_BOTH) ? 36 : 0;
      if (hold) hold_trigger = 1'b1;
      for (int k = 0; k < items; k++) begin
         s.new_capture = (k == 0) ||
                         (restart_odds != 0 && $urandom_range(0, restart_odds - 1) == 0);
         s.re          = random_value(store_re[s.new_capture ? 0 : store_slot()]);
         s.im          = random_value(store_im[s.new_capture ? 0 : store_slot()]);
         push_sample(s, 1'b0, '0);
      end
   endtask

   // response side: random stalls, and a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      logic [ENERGY_BITS-1:0] want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_energy.size() == 0) begin
               report_mismatch($sformatf("energy %0d with nothing pending", rsp_if.energy));
            end else begin
               want = pending_energy.pop_front();
               checked_count++;
               if (rsp_if.energy !== want)
                  report_mismatch($sformatf("energy got %0d want %0d", rsp_if.energy, want));
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout: %0d energy results still pending", pending_energy.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.real_part   <= '0;
      req_if.imag_part   <= '0;
      req_if.new_capture <= 1'b0;

      // reset length, then shrink mid-frame
      add_sample(100, -100, 1, 0, 0);
      add_sample(5, 5, 0, 0, 0);
      add_len(2);
      add_sample(7, 7, 0, 0, 0);
      add_sample(103, -96, 0, 0, 0);
      add_sample(8, 9, 0, 1, 1280);
      // one subcarrier per frame, field extremes
      add_len(1);
      add_sample(-32768, -32768, 0, 0, 0);
      add_sample(32767, 32767, 0, 0, 0);
      add_sample(32767, 32767, 0, 1, 0);
      add_sample(-32768, 32767, 0, 1, 16776960);
      add_sample(0, 0, 1, 0, 0);
      add_sample(3, -4, 0, 1, 1280);
      // zero length acts as one
      add_len(0);
      add_sample(3, -4, 0, 1, 0);
      add_sample(-1, 0, 0, 0, 0);
      add_sample(0, 0, 1, 0, 0);
      add_sample(0, 1, 0, 1, 256);
      // capture restart in the middle of a first frame
      add_len(3);
      add_sample(1, 1, 1, 0, 0);
      add_sample(2, 2, 0, 0, 0);
      add_sample(-32768, 32767, 1, 0, 0);
      add_sample(0, 0, 0, 0, 0);
      add_sample(0, 0, 0, 0, 0);
      add_sample(-32768, 32767, 0, 0, 0);
      add_sample(0, 0, 0, 0, 0);
      add_sample(0, 0, 0, 1, 0);
      add_sample(32767, -32768, 0, 0, 0);
      add_sample(-1, -1, 0, 0, 0);
      add_sample(1, 1, 0, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_len) write_frame_len(directed_rows[i].len);
         else push_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].energy);
      end

      run_phase(9'd1,   80,  IDLE_NONE,     1'b1, 80);
      run_phase(9'd3,   90,  IDLE_SENDER,   1'b0, 80);
      run_phase(9'd511, 520, IDLE_BOTH,     1'b0, 0);
      run_phase(9'd0,   40,  IDLE_RECEIVER, 1'b0, 80);
      run_phase(9'd7,   100, IDLE_BOTH,     1'b0, 80);
      run_phase(9'd2,   100, IDLE_SENDER,   1'b0, 80);
      run_phase(9'd16,  120, IDLE_RECEIVER, 1'b0, 80);
      settle();

      $display("%0d samples sent, %0d energy results checked, %0d mismatches",
               sent_count, checked_count, error_count);
      $display("frame lengths 0 to 511, capture restarts, idle and stall mixes, output hold-off");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/fdre_pkg.sv
hw/rtl/fdre_req_if.sv
hw/rtl/fdre_rsp_if.sv
hw/rtl/fdre_ctrl.sv
hw/rtl/fdre_datapath.sv
hw/rtl/frame_difference_rms_energy_top.sv
tb/sv/tb_top.sv
